[hdl/bfs_pkg.sv]
// Shared types, constants and command codes for the bitplane fine-scroll shifter.
package bfs_pkg;

  localparam int WORD_W = 16;
  localparam int NIB_W = 4;
  localparam int EDGE_W = 12;

  localparam int WRAP_WIDTH_DEF = 640;
  localparam int EDGE_THRESHOLD_DEF = 320;

  localparam logic [WORD_W-1:0] COARSE_MASK = 16'hfff8;
  localparam logic [WORD_W-1:0] FULL_MASK = 16'hffff;
  localparam logic [NIB_W-1:0] NIB_MASK = 4'hf;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_COLUMN = 2'd1,
    CMD_SEAM = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic [WORD_W-1:0] delta;
    logic [WORD_W-1:0] low_word;
    logic [WORD_W-1:0] high_word;
    logic [WORD_W-1:0] dest_word;
  } req_t;

endpackage

[hdl/bitplane_fine_scroll_shifter_core.sv]
// Top level of the bitplane fine-scroll shifter: input stage and execute stage.
//
// Requests enter on the in_ channel and are taken at a clock edge where in_valid is
// high and in_stall is low. Each request gives exactly one result on the out_ channel,
// taken where out_valid is high and out_stall is low.
// A request passes through an input register, where the slope-speed product is formed,
// and then the execute stage, which updates the scroll position and fills the result
// register. The result register is loaded from the input register once the execute
// stage may advance, which a stall on the out_ channel can delay.
// One request is taken every cycle while the receiver keeps out_stall low; the position
// register is read and written in the same cycle, so successive frame requests follow
// each other directly.
// When the receiver stalls, the result register holds its contents, the input register
// fills, and in_stall rises once both are occupied; nothing is lost or repeated.
// A synchronous reset on rst_n clears the scroll position to zero and empties both
// stages.
module bitplane_fine_scroll_shifter_core import bfs_pkg::*; #(
  parameter int WRAP_WIDTH = WRAP_WIDTH_DEF,
  parameter int EDGE_THRESHOLD = EDGE_THRESHOLD_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_cmd,
  input  logic signed [WORD_W-1:0] in_road_slope,
  input  logic signed [WORD_W-1:0] in_scroll_speed,
  input  logic [WORD_W-1:0]        in_low_word,
  input  logic [WORD_W-1:0]        in_high_word,
  input  logic [WORD_W-1:0]        in_dest_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [WORD_W-1:0]        out_position,
  output logic [WORD_W-1:0]        out_step_double,
  output logic [NIB_W-1:0]         out_fine_shift,
  output logic signed [WORD_W-1:0] out_coarse_offset,
  output logic                     out_wrap_active,
  output logic [EDGE_W-1:0]        out_edge_columns,
  output logic [WORD_W-1:0]        out_pixel_word
);

  logic down_free;
  logic req_valid;
  req_t req;

  bfs_mul_stage u_mul (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_road_slope   (in_road_slope),
    .in_scroll_speed (in_scroll_speed),
    .in_low_word     (in_low_word),
    .in_high_word    (in_high_word),
    .in_dest_word    (in_dest_word),
    .down_free       (down_free),
    .req_valid       (req_valid),
    .req             (req)
  );

  bfs_exec #(
    .WRAP_WIDTH     (WRAP_WIDTH),
    .EDGE_THRESHOLD (EDGE_THRESHOLD)
  ) u_exec (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req_valid),
    .req               (req),
    .down_free         (down_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_position      (out_position),
    .out_step_double   (out_step_double),
    .out_fine_shift    (out_fine_shift),
    .out_coarse_offset (out_coarse_offset),
    .out_wrap_active   (out_wrap_active),
    .out_edge_columns  (out_edge_columns),
    .out_pixel_word    (out_pixel_word)
  );

endmodule

[hdl/bfs_mul_stage.sv]
// Input register stage: captures a request and the low word of the slope-speed product.
module bfs_mul_stage import bfs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_cmd,
  input  logic signed [WORD_W-1:0] in_road_slope,
  input  logic signed [WORD_W-1:0] in_scroll_speed,
  input  logic [WORD_W-1:0]        in_low_word,
  input  logic [WORD_W-1:0]        in_high_word,
  input  logic [WORD_W-1:0]        in_dest_word,
  input  logic                     down_free,
  output logic                     req_valid,
  output req_t                     req
);

  logic signed [2*WORD_W-1:0] prod;
  logic                       valid_r;
  logic                       valid_nxt;
  req_t                       req_r;
  req_t                       req_nxt;
  logic                       load;

  assign prod = in_road_slope * in_scroll_speed;
  assign in_stall = valid_r && !down_free;
  assign load = in_valid && !in_stall;

  always_comb begin
    req_nxt = req_r;
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
    if (load) begin
      req_nxt.cmd = cmd_t'(in_cmd);
      req_nxt.delta = prod[WORD_W-1:0];
      req_nxt.low_word = in_low_word;
      req_nxt.high_word = in_high_word;
      req_nxt.dest_word = in_dest_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    req_r <= req_nxt;
  end

  assign req_valid = valid_r;
  assign req = req_r;

endmodule

[hdl/bfs_exec.sv]
// Execute stage: scroll position state, shift and merge logic, and the result register.
module bfs_exec import bfs_pkg::*; #(
  parameter int WRAP_WIDTH = WRAP_WIDTH_DEF,
  parameter int EDGE_THRESHOLD = EDGE_THRESHOLD_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     req_valid,
  input  req_t                     req,
  output logic                     down_free,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [WORD_W-1:0]        out_position,
  output logic [WORD_W-1:0]        out_step_double,
  output logic [NIB_W-1:0]         out_fine_shift,
  output logic signed [WORD_W-1:0] out_coarse_offset,
  output logic                     out_wrap_active,
  output logic [EDGE_W-1:0]        out_edge_columns,
  output logic [WORD_W-1:0]        out_pixel_word
);

  localparam logic [WORD_W-1:0] WRAP_W = WORD_W'(WRAP_WIDTH);
  localparam logic [WORD_W-1:0] EDGE_T = WORD_W'(EDGE_THRESHOLD);

  logic [WORD_W-1:0]   pos_r;
  logic [WORD_W-1:0]   pos_nxt;
  logic                valid_r;
  logic                valid_nxt;
  logic [WORD_W-1:0]   position_r;
  logic [WORD_W-1:0]   step_double_r;
  logic [NIB_W-1:0]    fine_shift_r;
  logic [WORD_W-1:0]   coarse_offset_r;
  logic                wrap_active_r;
  logic [EDGE_W-1:0]   edge_columns_r;
  logic [WORD_W-1:0]   pixel_word_r;

  logic                adv;
  logic [WORD_W-1:0]   sum;
  logic [WORD_W-1:0]   sum_less;
  logic [WORD_W-1:0]   wrapped;
  logic [NIB_W-1:0]    shift;
  logic [2*WORD_W-1:0] col_sh;
  logic [2*WORD_W-1:0] frac_sh;
  logic [WORD_W-1:0]   mask;
  logic [WORD_W-1:0]   pixel;
  logic [WORD_W-1:0]   step2;
  logic [WORD_W-1:0]   diff;
  logic                active;

  assign down_free = !valid_r || !out_stall;
  assign adv = req_valid && down_free;

  always_comb begin
    sum = pos_r + req.delta;
    sum_less = sum - WRAP_W;
    if (sum[WORD_W-1]) begin
      wrapped = sum + WRAP_W;
    end else if (!sum_less[WORD_W-1]) begin
      wrapped = sum_less;
    end else begin
      wrapped = sum;
    end
    pos_nxt = pos_r;
    step2 = '0;
    if (adv && req.cmd == CMD_FRAME) begin
      pos_nxt = wrapped;
      step2 = {req.delta[WORD_W-2:0], 1'b0};
    end
    shift = pos_nxt[NIB_W-1:0] & NIB_MASK;
    col_sh = {req.low_word, req.high_word} << shift;
    frac_sh = {{WORD_W{1'b0}}, req.low_word} << shift;
    mask = FULL_MASK << shift;
    case (req.cmd)
      CMD_COLUMN: pixel = col_sh[2*WORD_W-1:WORD_W];
      CMD_SEAM: pixel = (req.dest_word & mask) | frac_sh[2*WORD_W-1:WORD_W];
      default: pixel = '0;
    endcase
    diff = pos_nxt - EDGE_T;
    active = !diff[WORD_W-1];
    valid_nxt = valid_r;
    if (down_free) begin
      valid_nxt = req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      valid_r <= valid_nxt;
    end
    if (adv) begin
      position_r <= pos_nxt;
      step_double_r <= step2;
      fine_shift_r <= shift;
      coarse_offset_r <= {pos_nxt[WORD_W-1], pos_nxt[WORD_W-1:1]} & COARSE_MASK;
      wrap_active_r <= active;
      edge_columns_r <= active ? diff[WORD_W-1:NIB_W] : '0;
      pixel_word_r <= pixel;
    end
  end

  assign out_valid = valid_r;
  assign out_position = position_r;
  assign out_step_double = step_double_r;
  assign out_fine_shift = fine_shift_r;
  assign out_coarse_offset = coarse_offset_r;
  assign out_wrap_active = wrap_active_r;
  assign out_edge_columns = edge_columns_r;
  assign out_pixel_word = pixel_word_r;

  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && req.cmd != CMD_FRAME) |=> $stable(pos_r))
    else $error("Position changed on a non-frame request.");

  a_frame_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && step_double_r != '0) |-> (pixel_word_r == '0))
    else $error("Frame result carries a pixel word.");

  a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !wrap_active_r) |-> (edge_columns_r == '0))
    else $error("Edge columns reported while wrap is inactive.");

  a_shift_match: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (fine_shift_r == position_r[NIB_W-1:0] && position_r == pos_r))
    else $error("Result does not match the stored position.");

  a_reset_pos: assert property (@(posedge clk)
    !rst_n |=> (pos_r == '0 && !valid_r))
    else $error("Reset did not clear the position.");

endmodule

[sim/bitplane_fine_scroll_shifter_core_tb.sv]
// Self-checking testbench for the fine-scroll shifter core: directed corners, then random requests.
`timescale 1ns / 100ps

module bitplane_fine_scroll_shifter_core_tb;
  import bfs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [WORD_W-1:0] position;
    logic [WORD_W-1:0] step_double;
    logic [NIB_W-1:0]  fine_shift;
    logic [WORD_W-1:0] coarse_offset;
    logic              wrap_active;
    logic [EDGE_W-1:0] edge_columns;
    logic [WORD_W-1:0] pixel_word;
  } scroll_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_cmd = CMD_FRAME;
  logic signed [WORD_W-1:0] in_road_slope = '0;
  logic signed [WORD_W-1:0] in_scroll_speed = '0;
  logic [WORD_W-1:0]        in_low_word = '0;
  logic [WORD_W-1:0]        in_high_word = '0;
  logic [WORD_W-1:0]        in_dest_word = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [WORD_W-1:0]        out_position;
  logic [WORD_W-1:0]        out_step_double;
  logic [NIB_W-1:0]         out_fine_shift;
  logic signed [WORD_W-1:0] out_coarse_offset;
  logic                     out_wrap_active;
  logic [EDGE_W-1:0]        out_edge_columns;
  logic [WORD_W-1:0]        out_pixel_word;

  scroll_result_t    pending_results[$];
  logic [WORD_W-1:0] scroll_pos = '0;
  int                fail_count = 0;
  int                cycle_count = 0;
  bit                valid_up = 1'b0;
  int                gap_max = 0;
  int                burst_max = 1;
  int                burst_left = 1;
  int                stall_pct = 0;
  int                stall_run = 0;
  bit                stall_now = 1'b0;

  bitplane_fine_scroll_shifter_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_road_slope    (in_road_slope),
    .in_scroll_speed  (in_scroll_speed),
    .in_low_word      (in_low_word),
    .in_high_word     (in_high_word),
    .in_dest_word     (in_dest_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_position     (out_position),
    .out_step_double  (out_step_double),
    .out_fine_shift   (out_fine_shift),
    .out_coarse_offset(out_coarse_offset),
    .out_wrap_active  (out_wrap_active),
    .out_edge_columns (out_edge_columns),
    .out_pixel_word   (out_pixel_word)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // The receiver holds each stall decision for a run of random length.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_now = ($urandom_range(99) < stall_pct);
      stall_run = $urandom_range(1, 12);
    end
    stall_run = stall_run - 1;
    out_stall <= stall_now;
  end

  function automatic logic [WORD_W-1:0] rotate_pair_low(logic [31:0] pair, logic [NIB_W-1:0] s);
    logic [63:0] doubled;
    doubled = {pair, pair} << s;
    return doubled[32 +: WORD_W];
  endfunction

  function automatic scroll_result_t predict_scroll_result(cmd_t cmd, logic [WORD_W-1:0] slope,
      logic [WORD_W-1:0] speed, logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
      logic [WORD_W-1:0] dst);
    scroll_result_t    r;
    logic [31:0]       product;
    logic [WORD_W-1:0] delta;
    logic [WORD_W-1:0] h;
    logic [WORD_W-1:0] below_wrap;
    logic [WORD_W-1:0] diff;
    logic [WORD_W-1:0] mask;
    r.step_double = '0;
    r.pixel_word = '0;
    if (cmd == CMD_FRAME) begin
      product = {16'h0, slope} * {16'h0, speed};
      delta = product[WORD_W-1:0];
      r.step_double = {delta[WORD_W-2:0], 1'b0};
      h = scroll_pos + delta;
      below_wrap = h - WORD_W'(WRAP_WIDTH_DEF);
      if (h[WORD_W-1]) begin
        h = h + WORD_W'(WRAP_WIDTH_DEF);
      end else if (!below_wrap[WORD_W-1]) begin
        h = below_wrap;
      end
      scroll_pos = h;
    end
    h = scroll_pos;
    r.position = h;
    r.fine_shift = h[NIB_W-1:0] & NIB_MASK;
    if (cmd == CMD_COLUMN) begin
      r.pixel_word = rotate_pair_low({hi, lo}, r.fine_shift);
    end else if (cmd == CMD_SEAM) begin
      mask = FULL_MASK << r.fine_shift;
      r.pixel_word = (dst & mask) | rotate_pair_low({lo, 16'h0}, r.fine_shift);
    end
    r.coarse_offset = {h[WORD_W-1], h[WORD_W-1:1]} & COARSE_MASK;
    diff = h - WORD_W'(EDGE_THRESHOLD_DEF);
    r.wrap_active = !diff[WORD_W-1];
    r.edge_columns = r.wrap_active ? diff[WORD_W-1:4] : '0;
    return r;
  endfunction

  task automatic set_valid(bit v);
    if (valid_up != v) begin
      in_valid <= v;
      valid_up = v;
    end
  endtask

  task automatic send_request(cmd_t cmd, logic [WORD_W-1:0] slope, logic [WORD_W-1:0] speed,
      logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi, logic [WORD_W-1:0] dst);
    in_cmd <= cmd;
    in_road_slope <= slope;
    in_scroll_speed <= speed;
    in_low_word <= lo;
    in_high_word <= hi;
    in_dest_word <= dst;
    set_valid(1'b1);
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_scroll_result(cmd, slope, speed, lo, hi, dst));
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, burst_max);
      if (gap_max > 0) begin
        set_valid(1'b0);
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_for_drain();
    set_valid(1'b0);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    scroll_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("Result received with no request outstanding.");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("position", want.position, out_position);
        check_field("step_double", want.step_double, out_step_double);
        check_field("fine_shift", WORD_W'(want.fine_shift), WORD_W'(out_fine_shift));
        check_field("coarse_offset", want.coarse_offset, out_coarse_offset);
        check_field("wrap_active", WORD_W'(want.wrap_active), WORD_W'(out_wrap_active));
        check_field("edge_columns", WORD_W'(want.edge_columns), WORD_W'(out_edge_columns));
        check_field("pixel_word", want.pixel_word, out_pixel_word);
      end
    end
  end

  task automatic test_frame_advance();
    send_request(CMD_FRAME, 16'd0, 16'd0, 16'h0, 16'h0, 16'h0);
    send_request(CMD_FRAME, 16'd1, 16'd7, 16'hffff, 16'hffff, 16'hffff);
    send_request(CMD_FRAME, 16'd1, 16'd1000, 16'h0, 16'h0, 16'h0);
    send_request(CMD_FRAME, 16'hffff, 16'd400, 16'h0, 16'h0, 16'h0);
    send_request(CMD_FRAME, 16'h7fff, 16'h7fff, 16'h0, 16'h0, 16'h0);
    send_request(CMD_FRAME, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0);
    send_request(CMD_FRAME, 16'h8000, 16'd1, 16'h0, 16'h0, 16'h0);
    send_request(CMD_FRAME, 16'h7fff, 16'd1, 16'h0, 16'h0, 16'h0);
    send_request(CMD_FRAME, 16'd1, -16'sd607, 16'h0, 16'h0, 16'h0);
  endtask

  task automatic test_column_shift();
    send_request(CMD_COLUMN, 16'h0, 16'h0, 16'h1234, 16'hffff, 16'h0);
    send_request(CMD_FRAME, 16'd1, 16'd15, 16'h0, 16'h0, 16'h0);
    send_request(CMD_COLUMN, 16'h0, 16'h0, 16'h8001, 16'h8001, 16'h0);
    send_request(CMD_COLUMN, 16'h0, 16'h0, 16'h0000, 16'hffff, 16'h0);
    send_request(CMD_COLUMN, 16'h0, 16'h0, 16'hffff, 16'h0000, 16'h0);
  endtask

  task automatic test_seam_merge();
    send_request(CMD_SEAM, 16'h0, 16'h0, 16'hffff, 16'h0, 16'h0000);
    send_request(CMD_SEAM, 16'h0, 16'h0, 16'h0000, 16'h0, 16'hffff);
    send_request(CMD_SEAM, 16'h0, 16'h0, 16'ha5a5, 16'h0, 16'h5a5a);
    send_request(CMD_FRAME, 16'd1, -16'sd15, 16'h0, 16'h0, 16'h0);
    send_request(CMD_SEAM, 16'h0, 16'h0, 16'hffff, 16'h0, 16'ha5a5);
  endtask

  task automatic test_unused_command();
    send_request(CMD_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_request(CMD_UNUSED, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
  endtask

  task automatic test_random_traffic(int count, int gaps, int bursts, int stalls);
    cmd_t              cmd;
    int                pick;
    int                small_slope;
    int                small_speed;
    logic [WORD_W-1:0] slope;
    logic [WORD_W-1:0] speed;
    gap_max = gaps;
    burst_max = bursts;
    burst_left = 1;
    stall_pct = stalls;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 35) cmd = CMD_FRAME;
      else if (pick < 65) cmd = CMD_COLUMN;
      else if (pick < 93) cmd = CMD_SEAM;
      else cmd = CMD_UNUSED;
      // Half the requests use small factors, which move the position in small steps across the wrap and edge limits.
      if ($urandom_range(1) == 1) begin
        slope = WORD_W'($urandom);
        speed = WORD_W'($urandom);
      end else begin
        small_slope = $urandom_range(0, 128) - 64;
        small_speed = $urandom_range(0, 32) - 16;
        slope = small_slope[WORD_W-1:0];
        speed = small_speed[WORD_W-1:0];
      end
      send_request(cmd, slope, speed, WORD_W'($urandom), WORD_W'($urandom),
                   WORD_W'($urandom));
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_max = 3;
    burst_max = 4;
    stall_pct = 30;
    test_frame_advance();
    test_column_shift();
    test_seam_merge();
    test_unused_command();
    wait_for_drain();
    test_random_traffic(450, 0, 1, 0);
    test_random_traffic(850, 6, 8, 30);
    test_random_traffic(450, 3, 4, 70);
    stall_pct = 0;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/bfs_pkg.sv
hdl/bfs_mul_stage.sv
hdl/bfs_exec.sv
hdl/bitplane_fine_scroll_shifter_core.sv
sim/bitplane_fine_scroll_shifter_core_tb.sv
